FILE: hdl/mscc_pkg.sv
// Shared types, widths and codes of the marching-squares contour cell block.
// No dependencies; every other file takes its names from here by scope.
package mscc_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int LEVEL_W      = SAMPLE_W + 2;
    localparam int SUM4_W       = LEVEL_W + 2;
    localparam int IV_W         = 31;
    localparam int COL_W        = 12;
    localparam int MAX_COLUMNS  = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS);
    localparam int MASK_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_ITERS    = SAMPLE_W / DIV_STEPS;
    localparam int DIV_CNT_W    = $clog2(DIV_ITERS);

    localparam logic [COL_W-1:0] LAST_COLUMN = COL_W'(MAX_COLUMNS - 1);
    localparam logic [SEG_CNT_W-1:0] LAST_SEG = SEG_CNT_W'(MAX_SEGMENTS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_ITERS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZERO = CFG_IDX_W'(1);

    // side masks: bit0 top, bit1 right, bit2 bottom, bit3 left
    localparam logic [MASK_W-1:0] MASK_TOP_LEFT     = 4'h9;
    localparam logic [MASK_W-1:0] MASK_BOTTOM_RIGHT = 4'h6;
    localparam logic [MASK_W-1:0] MASK_TOP_RIGHT    = 4'h3;
    localparam logic [MASK_W-1:0] MASK_BOTTOM_LEFT  = 4'hC;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIRST,
        ST_LEVEL,
        ST_SADDLE2
    } seq_state_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] dividend;
        logic [IV_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [IV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [MASK_W-1:0] hits;
        logic              pair;
        logic              saddle;
        logic              split_tl;
    } eval_t;

endpackage

FILE: hdl/mscc_in_if.sv
// Input sample channel: one beat per raster column.
// Depends on mscc_pkg for the sample type.
interface mscc_in_if;
    logic               valid;
    logic               ready;
    mscc_pkg::sample_t  top_sample;
    mscc_pkg::sample_t  bottom_sample;
    logic               row_start;

    modport source (output valid, output top_sample, output bottom_sample,
                    output row_start, input ready);
    modport sink (input valid, input top_sample, input bottom_sample,
                  input row_start, output ready);
endinterface

FILE: hdl/mscc_out_if.sv
// Segment result channel: one beat per contour segment.
// Depends on mscc_pkg for widths.
interface mscc_out_if;
    logic                              valid;
    logic                              ready;
    mscc_pkg::sample_t                 level_value;
    logic [mscc_pkg::MASK_W-1:0]       side_mask;
    logic [mscc_pkg::COL_W-1:0]        cell_column;
    logic                              last_segment;
    logic                              truncated;

    modport source (output valid, output level_value, output side_mask,
                    output cell_column, output last_segment, output truncated,
                    input ready);
    modport sink (input valid, input level_value, input side_mask,
                  input cell_column, input last_segment, input truncated,
                  output ready);
endinterface

FILE: hdl/mscc_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on mscc_pkg for widths.
interface mscc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mscc_pkg::CFG_IDX_W-1:0]      index;
    logic [mscc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/mscc_rem_unit.sv
// Iterative restoring remainder unit, two quotient bits per cycle.
// Depends on mscc_pkg for the request and response structs.
module mscc_rem_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  mscc_pkg::div_req_t req,
    output mscc_pkg::div_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [mscc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mscc_pkg::SAMPLE_W-1:0]    shift_reg, shift_next;
    logic [mscc_pkg::IV_W-1:0]        rem_reg, rem_next;
    logic [mscc_pkg::IV_W-1:0]        dvs_reg, dvs_next;

    always_comb
    begin
        logic [mscc_pkg::IV_W:0]       trial;
        logic [mscc_pkg::IV_W-1:0]     r;
        logic [mscc_pkg::SAMPLE_W-1:0] s;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        trial = '0;
        r = rem_reg;
        s = shift_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < mscc_pkg::DIV_STEPS; k++)
            begin
                trial = {r, s[mscc_pkg::SAMPLE_W-1]};
                s = {s[mscc_pkg::SAMPLE_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg})
                begin
                    trial = trial - {1'b0, dvs_reg};
                end
                r = trial[mscc_pkg::IV_W-1:0];
            end
            rem_next   = r;
            shift_next = s;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == mscc_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hdl/mscc_level_eval.sv
// Side crossing test of one cell at one contour level, with saddle split.
// Depends on mscc_pkg for the level type and the result struct.
module mscc_level_eval
(
    input  mscc_pkg::sample_t  corner [4],
    input  mscc_pkg::level_t   level,
    input  mscc_pkg::level_t   sum,
    output mscc_pkg::eval_t    result
);

    logic [3:0]                          above;
    logic [mscc_pkg::MASK_W-1:0]         hits;
    logic signed [mscc_pkg::SUM4_W-1:0]  level4;
    logic signed [mscc_pkg::SUM4_W-1:0]  sum_ext;

    // corner order: top-left, top-right, bottom-right, bottom-left
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            above[i] = mscc_pkg::level_t'(corner[i]) > level;
        end
        for (int i = 0; i < 4; i++)
        begin
            hits[i] = above[i] ^ above[(i + 1) % 4];
        end
    end

    assign level4  = mscc_pkg::SUM4_W'(level) <<< 2;
    assign sum_ext = mscc_pkg::SUM4_W'(sum);

    assign result.hits     = hits;
    assign result.pair     = ($countones(hits) == 2);
    assign result.saddle   = ($countones(hits) == 4);
    // top-left corner at or below the level while the mean is above, or the reverse
    assign result.split_tl = above[0] ^ (level4 < sum_ext);

endmodule

FILE: hdl/marching_squares_contour_cells.sv
// Marching-squares contour cell extractor: top level with sequencer.
// Depends on mscc_pkg, the three channel interfaces, mscc_rem_unit and
// mscc_level_eval.
//
// Feed two raster rows one column per beat on the samples channel; the
// previous column is kept, so each beat after a row start closes a square
// cell whose left edge is the previous column. For every multiple of
// contour_interval from the corner minimum up to (not including) the
// corner maximum the block emits one segment, or two for a saddle, in
// ascending level order, each carrying level, side mask and column; the
// last segment of a cell is flagged, and truncated is set on it when the
// cap of 64 segments per cell cut the list short. The block works on one
// cell at a time and drops ready meanwhile. A row start, an ignored
// column or a skipped cell leaves the sequencer idle. A cell that is
// worked out is accepted, then has minimum, maximum and sum found, then
// has the magnitude of its minimum reduced in the remainder unit (two
// quotient bits a cycle) to set the first level, which is then checked
// against the maximum; each level then emits its segment, a saddle a
// second one, stretched by any stall on the segments channel. The segment
// register lets the next column be accepted while the final segment
// still waits.
module marching_squares_contour_cells
(
    input  logic        clk,
    input  logic        rst_n,
    mscc_cfg_if.sink    cfg,
    mscc_in_if.sink     samples,
    mscc_out_if.source  segments
);

    // configuration
    logic [mscc_pkg::IV_W-1:0]      iv_reg;
    logic                           skip_reg;
    logic [mscc_pkg::IV_W-1:0]      iv_eff;

    // column history
    mscc_pkg::sample_t              prev_top_reg, prev_top_next;
    mscc_pkg::sample_t              prev_bot_reg, prev_bot_next;
    logic                           have_prev_reg, have_prev_next;
    logic [mscc_pkg::COL_W-1:0]     col_count_reg, col_count_next;

    // cell being worked on
    mscc_pkg::seq_state_t           state_reg, state_next;
    mscc_pkg::sample_t              corner_reg [4];
    mscc_pkg::sample_t              corner_next [4];
    logic [mscc_pkg::COL_W-1:0]     cell_col_reg, cell_col_next;
    mscc_pkg::sample_t              lo_reg, lo_next;
    mscc_pkg::sample_t              hi_reg, hi_next;
    mscc_pkg::level_t               sum_reg, sum_next;
    mscc_pkg::level_t               level_reg, level_next;
    logic                           live_reg, live_next;
    logic [mscc_pkg::SEG_CNT_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic [mscc_pkg::MASK_W-1:0]    mask2_reg, mask2_next;

    // segment output register
    logic                           out_valid_reg, out_valid_next;
    mscc_pkg::sample_t              out_level_reg, out_level_next;
    logic [mscc_pkg::MASK_W-1:0]    out_mask_reg, out_mask_next;
    logic [mscc_pkg::COL_W-1:0]     out_col_reg, out_col_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_trunc_reg, out_trunc_next;

    mscc_pkg::div_req_t             div_req;
    mscc_pkg::div_rsp_t             div_rsp;
    mscc_pkg::eval_t                eval;
    mscc_pkg::level_t               step_level;
    logic                           step_live;
    logic                           slot_free;
    logic                           in_beat;

    assign iv_eff    = (iv_reg == '0) ? mscc_pkg::IV_W'(1) : iv_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg   <= mscc_pkg::IV_W'(1);
            skip_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mscc_pkg::CFG_INTERVAL:
                begin
                    iv_reg <= cfg.data[mscc_pkg::IV_W-1:0];
                end
                mscc_pkg::CFG_SKIP_ZERO:
                begin
                    skip_reg <= cfg.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    mscc_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mscc_level_eval u_eval
    (
        .corner (corner_reg),
        .level  (level_reg),
        .sum    (sum_reg),
        .result (eval)
    );

    // next level and whether it still lies below the corner maximum
    assign step_level = level_reg + mscc_pkg::LEVEL_W'(iv_eff);
    assign step_live  = step_level < mscc_pkg::level_t'(hi_reg);

    assign slot_free     = !out_valid_reg || segments.ready;
    assign samples.ready = (state_reg == mscc_pkg::ST_IDLE);
    assign in_beat       = samples.valid && samples.ready;

    always_comb
    begin
        mscc_pkg::sample_t lo_a, lo_b, hi_a, hi_b;
        logic              any_zero;
        logic              more;
        logic [mscc_pkg::MASK_W-1:0] mask;

        state_next     = state_reg;
        prev_top_next  = prev_top_reg;
        prev_bot_next  = prev_bot_reg;
        have_prev_next = have_prev_reg;
        col_count_next = col_count_reg;
        corner_next    = corner_reg;
        cell_col_next  = cell_col_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        level_next     = level_reg;
        live_next      = live_reg;
        seg_cnt_next   = seg_cnt_reg;
        mask2_next     = mask2_reg;

        out_valid_next = out_valid_reg && !segments.ready;
        out_level_next = out_level_reg;
        out_mask_next  = out_mask_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;

        div_req.start    = 1'b0;
        div_req.divisor  = iv_eff;

        lo_a     = '0;
        lo_b     = '0;
        hi_a     = '0;
        hi_b     = '0;
        any_zero = 1'b0;
        more     = 1'b0;
        mask     = '0;

        unique case (state_reg)
            mscc_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (samples.row_start || !have_prev_reg)
                    begin
                        prev_top_next  = samples.top_sample;
                        prev_bot_next  = samples.bottom_sample;
                        have_prev_next = 1'b1;
                        col_count_next = '0;
                    end
                    else if (col_count_reg < mscc_pkg::LAST_COLUMN)
                    begin
                        corner_next[0] = prev_top_reg;
                        corner_next[1] = samples.top_sample;
                        corner_next[2] = samples.bottom_sample;
                        corner_next[3] = prev_bot_reg;
                        cell_col_next  = col_count_reg;
                        prev_top_next  = samples.top_sample;
                        prev_bot_next  = samples.bottom_sample;
                        col_count_next = col_count_reg + 1'b1;
                        any_zero = (prev_top_reg == '0) || (prev_bot_reg == '0) ||
                                   (samples.top_sample == '0) ||
                                   (samples.bottom_sample == '0);
                        if (!(skip_reg && any_zero))
                        begin
                            state_next = mscc_pkg::ST_PREP;
                        end
                    end
                end
            end

            mscc_pkg::ST_PREP:
            begin
                lo_a = (corner_reg[0] < corner_reg[1]) ? corner_reg[0] : corner_reg[1];
                lo_b = (corner_reg[2] < corner_reg[3]) ? corner_reg[2] : corner_reg[3];
                hi_a = (corner_reg[0] > corner_reg[1]) ? corner_reg[0] : corner_reg[1];
                hi_b = (corner_reg[2] > corner_reg[3]) ? corner_reg[2] : corner_reg[3];
                lo_next  = (lo_a < lo_b) ? lo_a : lo_b;
                hi_next  = (hi_a > hi_b) ? hi_a : hi_b;
                sum_next = mscc_pkg::level_t'(corner_reg[0]) + mscc_pkg::level_t'(corner_reg[1])
                         + mscc_pkg::level_t'(corner_reg[2]) + mscc_pkg::level_t'(corner_reg[3]);
                div_req.start = 1'b1;
                state_next    = mscc_pkg::ST_DIV;
            end

            mscc_pkg::ST_DIV:
            begin
                // first level: smallest multiple of the interval at or above lo
                if (div_rsp.done)
                begin
                    if (lo_reg[mscc_pkg::SAMPLE_W-1])
                    begin
                        level_next = mscc_pkg::level_t'(lo_reg)
                                   + mscc_pkg::LEVEL_W'(div_rsp.remainder);
                    end
                    else if (div_rsp.remainder != '0)
                    begin
                        level_next = mscc_pkg::level_t'(lo_reg)
                                   + mscc_pkg::LEVEL_W'(iv_eff)
                                   - mscc_pkg::LEVEL_W'(div_rsp.remainder);
                    end
                    else
                    begin
                        level_next = mscc_pkg::level_t'(lo_reg);
                    end
                    state_next = mscc_pkg::ST_FIRST;
                end
            end

            mscc_pkg::ST_FIRST:
            begin
                live_next    = level_reg < mscc_pkg::level_t'(hi_reg);
                seg_cnt_next = '0;
                state_next   = mscc_pkg::ST_LEVEL;
            end

            mscc_pkg::ST_LEVEL:
            begin
                if (!live_reg)
                begin
                    state_next = mscc_pkg::ST_IDLE;
                end
                else if (eval.pair || eval.saddle)
                begin
                    if (slot_free)
                    begin
                        more = eval.pair ? step_live : 1'b1;
                        mask = eval.pair ? eval.hits
                             : (eval.split_tl ? mscc_pkg::MASK_TOP_LEFT
                                              : mscc_pkg::MASK_TOP_RIGHT);
                        mask2_next = eval.split_tl ? mscc_pkg::MASK_BOTTOM_RIGHT
                                                   : mscc_pkg::MASK_BOTTOM_LEFT;
                        out_valid_next = 1'b1;
                        out_level_next = level_reg[mscc_pkg::SAMPLE_W-1:0];
                        out_mask_next  = mask;
                        out_col_next   = cell_col_reg;
                        out_last_next  = (seg_cnt_reg == mscc_pkg::LAST_SEG) || !more;
                        out_trunc_next = (seg_cnt_reg == mscc_pkg::LAST_SEG) && more;
                        seg_cnt_next   = seg_cnt_reg + 1'b1;
                        if ((seg_cnt_reg == mscc_pkg::LAST_SEG) || !more)
                        begin
                            state_next = mscc_pkg::ST_IDLE;
                        end
                        else if (eval.saddle)
                        begin
                            state_next = mscc_pkg::ST_SADDLE2;
                        end
                        else
                        begin
                            level_next = step_level;
                            live_next  = step_live;
                        end
                    end
                end
                else
                begin
                    // no closed pair at this level: advance
                    level_next = step_level;
                    live_next  = step_live;
                end
            end

            mscc_pkg::ST_SADDLE2:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg[mscc_pkg::SAMPLE_W-1:0];
                    out_mask_next  = mask2_reg;
                    out_col_next   = cell_col_reg;
                    out_last_next  = (seg_cnt_reg == mscc_pkg::LAST_SEG) || !step_live;
                    out_trunc_next = (seg_cnt_reg == mscc_pkg::LAST_SEG) && step_live;
                    seg_cnt_next   = seg_cnt_reg + 1'b1;
                    level_next     = step_level;
                    live_next      = step_live;
                    if ((seg_cnt_reg == mscc_pkg::LAST_SEG) || !step_live)
                    begin
                        state_next = mscc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mscc_pkg::ST_LEVEL;
                    end
                end
            end

            default:
            begin
                state_next = mscc_pkg::ST_IDLE;
            end
        endcase

        // magnitude of the new minimum, taken by the remainder unit on start
        div_req.dividend = lo_next[mscc_pkg::SAMPLE_W-1] ? mscc_pkg::SAMPLE_W'(-lo_next)
                                                         : mscc_pkg::SAMPLE_W'(lo_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mscc_pkg::ST_IDLE;
            prev_top_reg  <= '0;
            prev_bot_reg  <= '0;
            have_prev_reg <= 1'b0;
            col_count_reg <= '0;
            out_valid_reg <= 1'b0;
            live_reg      <= 1'b0;
            seg_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_top_reg  <= prev_top_next;
            prev_bot_reg  <= prev_bot_next;
            have_prev_reg <= have_prev_next;
            col_count_reg <= col_count_next;
            out_valid_reg <= out_valid_next;
            live_reg      <= live_next;
            seg_cnt_reg   <= seg_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg    <= corner_next;
        cell_col_reg  <= cell_col_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        sum_reg       <= sum_next;
        level_reg     <= level_next;
        mask2_reg     <= mask2_next;
        out_level_reg <= out_level_next;
        out_mask_reg  <= out_mask_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign segments.valid        = out_valid_reg;
    assign segments.level_value  = out_level_reg;
    assign segments.side_mask    = out_mask_reg;
    assign segments.cell_column  = out_col_reg;
    assign segments.last_segment = out_last_reg;
    assign segments.truncated    = out_trunc_reg;

endmodule
